@@ rtl/core/assert_macros.svh @@
// Assertion macros shared by the RTL.
// Define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
// same-cycle implication
`define ASSERT_HOLDS(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);
`else
`define ASSERT_HOLDS(label, clk, rst, ante, cons, msg)
`define ASSERT_NEXT(label, clk, rst, ante, cons, msg)
`endif

`endif

@@ rtl/core/cer_pkg.sv @@
package cer_pkg;

   // field widths
   localparam int ENERGY_W = 32;
   localparam int GAIN_W   = 2;
   localparam int COEF_W   = 40;
   localparam int CNT_W    = 3;

   localparam int MAX_COEFFS       = 4;
   localparam int NUM_COEFF_FIELDS = 4;
   localparam int EFF_COEFFS = (MAX_COEFFS < NUM_COEFF_FIELDS) ? MAX_COEFFS : NUM_COEFF_FIELDS;
   localparam int COEF_IDX_W = $clog2(NUM_COEFF_FIELDS);

   // packed stream widths
   localparam int REQ_BITS    = ENERGY_W + 6 * COEF_W + CNT_W;
   localparam int REQ_TDATA_W = ((REQ_BITS + 7) / 8) * 8;
   localparam int RSP_TDATA_W = ENERGY_W;

   // config port
   localparam int CSR_INDEX_W = 1;
   localparam int CSR_DATA_W  = 1;
   localparam logic [CSR_INDEX_W-1:0] REG_USE_OLD_ICPT = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_USE_NEW_ICPT = 1'd1;

   // datapath widths
   localparam int SUM_W  = 36;
   localparam int QUO_W  = 33;
   localparam int LOOP_W = 6;
   localparam logic [LOOP_W-1:0] DIV_LOOP_INIT = LOOP_W'(QUO_W - 1);

   // microcode addresses
   localparam int STEP_W = 4;
   localparam logic [STEP_W-1:0] STEP_IDLE      = 4'd0;
   localparam logic [STEP_W-1:0] STEP_GATE      = 4'd1;
   localparam logic [STEP_W-1:0] STEP_DIV       = 4'd2;
   localparam logic [STEP_W-1:0] STEP_ADC_CLIP  = 4'd3;
   localparam logic [STEP_W-1:0] STEP_ADC_SUB   = 4'd4;
   localparam logic [STEP_W-1:0] STEP_CHK_TERMS = 4'd5;
   localparam logic [STEP_W-1:0] STEP_MUL_HI    = 4'd6;
   localparam logic [STEP_W-1:0] STEP_MUL_LO    = 4'd7;
   localparam logic [STEP_W-1:0] STEP_TERM_ACC  = 4'd8;
   localparam logic [STEP_W-1:0] STEP_MUL_POW   = 4'd9;
   localparam logic [STEP_W-1:0] STEP_POW_CLIP  = 4'd10;
   localparam logic [STEP_W-1:0] STEP_ADD_ICPT  = 4'd11;
   localparam logic [STEP_W-1:0] STEP_EMIT_SUM  = 4'd12;
   localparam logic [STEP_W-1:0] STEP_EMIT_PASS = 4'd13;

   typedef enum logic [3:0] {
      OP_NOP,
      OP_DIV_INIT,
      OP_DIV_STEP,
      OP_ADC_CLIP,
      OP_ADC_SUB,
      OP_MUL_HI,
      OP_MUL_LO,
      OP_TERM_ACC,
      OP_MUL_POW,
      OP_POW_CLIP,
      OP_ADD_ICPT,
      OP_EMIT_SUM,
      OP_EMIT_PASS
   } op_type;

   typedef enum logic [2:0] {
      COND_NEXT,
      COND_JUMP,
      COND_WAIT_ITEM,
      COND_NO_GATE,
      COND_LOOP,
      COND_NO_TERMS,
      COND_LAST_TERM
   } cond_type;

   typedef struct packed {
      op_type            op;
      cond_type          cond;
      logic [STEP_W-1:0] target;
      logic              load_loop;
      logic              wait_out;
   } ucode_type;

   typedef struct packed {
      op_type op;
      logic   load;
   } ctrl_type;

   typedef struct packed {
      logic gate_ok;
      logic more_terms;
      logic last_term;
      logic out_busy;
   } status_type;

   typedef struct packed {
      logic                sat;
      logic [ENERGY_W-1:0] val;
   } clip_type;

   localparam logic signed [SUM_W-1:0] CLIP_HI = SUM_W'(64'sd2147483647);
   localparam logic signed [SUM_W-1:0] CLIP_LO = SUM_W'(-64'sd2147483648);

   function automatic clip_type clip_sum(input logic signed [SUM_W-1:0] x);
      clip_type r;
      if (x > CLIP_HI) begin
         r.sat = 1'b1;
         r.val = CLIP_HI[ENERGY_W-1:0];
      end else if (x < CLIP_LO) begin
         r.sat = 1'b1;
         r.val = CLIP_LO[ENERGY_W-1:0];
      end else begin
         r.sat = 1'b0;
         r.val = x[ENERGY_W-1:0];
      end
      return r;
   endfunction

   // control store
   function automatic ucode_type ucode_rom(input logic [STEP_W-1:0] step);
      ucode_type w;
      w = '{op: OP_NOP, cond: COND_NEXT, target: STEP_IDLE, load_loop: 1'b0, wait_out: 1'b0};
      unique case (step)
         STEP_IDLE: begin
            w.cond   = COND_WAIT_ITEM;
            w.target = STEP_IDLE;
         end
         STEP_GATE: begin
            w.op        = OP_DIV_INIT;
            w.cond      = COND_NO_GATE;
            w.target    = STEP_EMIT_PASS;
            w.load_loop = 1'b1;
         end
         STEP_DIV: begin
            w.op     = OP_DIV_STEP;
            w.cond   = COND_LOOP;
            w.target = STEP_DIV;
         end
         STEP_ADC_CLIP:  w.op = OP_ADC_CLIP;
         STEP_ADC_SUB:   w.op = OP_ADC_SUB;
         STEP_CHK_TERMS: begin
            w.cond   = COND_NO_TERMS;
            w.target = STEP_ADD_ICPT;
         end
         STEP_MUL_HI:    w.op = OP_MUL_HI;
         STEP_MUL_LO:    w.op = OP_MUL_LO;
         STEP_TERM_ACC: begin
            w.op     = OP_TERM_ACC;
            w.cond   = COND_LAST_TERM;
            w.target = STEP_ADD_ICPT;
         end
         STEP_MUL_POW:   w.op = OP_MUL_POW;
         STEP_POW_CLIP: begin
            w.op     = OP_POW_CLIP;
            w.cond   = COND_JUMP;
            w.target = STEP_MUL_HI;
         end
         STEP_ADD_ICPT:  w.op = OP_ADD_ICPT;
         STEP_EMIT_SUM: begin
            w.op       = OP_EMIT_SUM;
            w.cond     = COND_JUMP;
            w.target   = STEP_IDLE;
            w.wait_out = 1'b1;
         end
         STEP_EMIT_PASS: begin
            w.op       = OP_EMIT_PASS;
            w.cond     = COND_JUMP;
            w.target   = STEP_IDLE;
            w.wait_out = 1'b1;
         end
         default: begin
            w.cond   = COND_JUMP;
            w.target = STEP_IDLE;
         end
      endcase
      return w;
   endfunction

endpackage

@@ rtl/core/cer_seq.sv @@
`include "assert_macros.svh"

module cer_seq import cer_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output ctrl_type   ctrl
);

   logic [STEP_W-1:0] step_ff, step_in;
   logic [LOOP_W-1:0] loop_ff, loop_in;
   ucode_type         word;
   logic              stall;
   logic              accept;
   logic              jump;

   assign word       = ucode_rom(step_ff);
   assign stall      = word.wait_out && status.out_busy;
   assign req_tready = (step_ff == STEP_IDLE);
   assign accept     = req_tvalid && req_tready;

   // jump decision
   always_comb begin
      unique case (word.cond)
         COND_NEXT:      jump = 1'b0;
         COND_JUMP:      jump = 1'b1;
         COND_WAIT_ITEM: jump = !accept;
         COND_NO_GATE:   jump = !status.gate_ok;
         COND_LOOP:      jump = (loop_ff != '0);
         COND_NO_TERMS:  jump = !status.more_terms;
         COND_LAST_TERM: jump = status.last_term;
         default:        jump = 1'b1;
      endcase
   end

   // next step
   always_comb begin
      priority if (stall) begin
         step_in = step_ff;
      end else if (jump) begin
         step_in = word.target;
      end else begin
         step_in = step_ff + 1'b1;
      end
   end

   // divide count is armed only when the gate opens
   always_comb begin
      priority if (word.load_loop && !jump) begin
         loop_in = DIV_LOOP_INIT;
      end else if (word.cond == COND_LOOP && loop_ff != '0) begin
         loop_in = loop_ff - 1'b1;
      end else begin
         loop_in = loop_ff;
      end
   end

   // outputs
   always_comb begin
      ctrl.op   = stall ? OP_NOP : word.op;
      ctrl.load = accept;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         step_ff <= STEP_IDLE;
         loop_ff <= '0;
      end else begin
         step_ff <= step_in;
         loop_ff <= loop_in;
      end
   end

   `ASSERT_NEXT(a_accept_starts, clock, reset, accept, step_ff == STEP_GATE, "item not started")
   `ASSERT_HOLDS(a_loop_in_div, clock, reset, loop_ff != '0, step_ff == STEP_DIV, "stray loop count")
   `ASSERT_NEXT(a_emit_returns, clock, reset, ctrl.op == OP_EMIT_SUM || ctrl.op == OP_EMIT_PASS, step_ff == STEP_IDLE, "no return to idle")

endmodule

@@ rtl/core/cer_dp.sv @@
`include "assert_macros.svh"

module cer_dp import cer_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  ctrl_type               ctrl,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [GAIN_W-1:0]      req_tuser,
   input  logic                   use_old_icpt,
   input  logic                   use_new_icpt,
   output status_type             status,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   output logic                   rsp_tuser
);

   localparam int E_LSB   = 0;
   localparam int OI_LSB  = E_LSB + ENERGY_W;
   localparam int OS_LSB  = OI_LSB + COEF_W;
   localparam int C0_LSB  = OS_LSB + COEF_W;
   localparam int CNT_LSB = C0_LSB + NUM_COEFF_FIELDS * COEF_W;
   localparam int MUL_W   = 32;
   localparam int HALF_W  = 20;
   localparam int HI_W    = HALF_W + MUL_W;

   // item registers
   logic signed [ENERGY_W-1:0] e_ff;
   logic                       not_high_ff;
   logic signed [COEF_W-1:0]   oi_ff;
   logic [COEF_W-1:0]          slope_ff;
   logic signed [COEF_W-1:0]   coef_ff [NUM_COEFF_FIELDS];
   logic [CNT_W-1:0]           cnt_ff;
   logic [CNT_W-1:0]           cnt_raw;

   // working registers
   logic [COEF_W-1:0]          rem_ff, rem_in;
   logic [QUO_W-1:0]           quo_ff, quo_in;
   logic                       ovf_ff, ovf_in;
   logic signed [ENERGY_W-1:0] adc_ff, adc_in;
   logic signed [ENERGY_W-1:0] p_ff, p_in;
   logic [CNT_W-1:0]           i_ff, i_in;
   logic [HI_W-1:0]            hi_ff, hi_in;
   logic [2*MUL_W-1:0]         prod_ff, prod_in;
   logic signed [SUM_W-1:0]    sum_ff, sum_in;
   logic                       sat_ff, sat_in;

   // result register
   logic                       out_valid_ff, out_valid_in;
   logic [ENERGY_W-1:0]        out_e_ff, out_e_in;
   logic                       out_sat_ff, out_sat_in;

   // combinational helpers
   logic [ENERGY_W-1:0]        e_mag;
   logic [COEF_W-1:0]          prefix;
   logic [COEF_W-1:0]          rem_sh;
   logic signed [COEF_W-1:0]   c_sel;
   logic [COEF_W-1:0]          c_mag;
   logic [MUL_W-1:0]           p_mag, adc_mag;
   logic [MUL_W-1:0]           mul_a, mul_b;
   logic signed [SUM_W-1:0]    v36;
   logic signed [COEF_W:0]     oi_t, c0_t;
   logic [HI_W:0]              term_sum;
   logic [SUM_W-1:0]           term_mag;
   logic [2*MUL_W-17:0]        pow_mag;
   logic                       term_neg, pow_neg;
   logic [CNT_W:0]             i_next;
   clip_type                   clip_r;

   assign cnt_raw = req_tdata[CNT_LSB +: CNT_W];

   assign e_mag   = e_ff[ENERGY_W-1] ? (~e_ff + 1'b1) : e_ff;
   assign prefix  = {1'b0, e_mag, 7'd0};
   assign rem_sh  = {rem_ff[COEF_W-2:0], 1'b0};
   assign c_sel   = coef_ff[i_ff[COEF_IDX_W-1:0]];
   assign c_mag   = c_sel[COEF_W-1] ? (~c_sel + 1'b1) : c_sel;
   assign p_mag   = p_ff[ENERGY_W-1] ? (~p_ff + 1'b1) : p_ff;
   assign adc_mag = adc_ff[ENERGY_W-1] ? (~adc_ff + 1'b1) : adc_ff;
   assign term_neg = c_sel[COEF_W-1] ^ p_ff[ENERGY_W-1];
   assign pow_neg  = p_ff[ENERGY_W-1] ^ adc_ff[ENERGY_W-1];
   assign i_next   = {1'b0, i_ff} + 1'b1;

   // truncating shifts toward zero
   assign oi_t = ($signed({oi_ff[COEF_W-1], oi_ff})
                  + $signed({25'd0, {16{oi_ff[COEF_W-1]}}})) >>> 16;
   assign c0_t = ($signed({coef_ff[0][COEF_W-1], coef_ff[0]})
                  + $signed({17'd0, {24{coef_ff[0][COEF_W-1]}}})) >>> 24;

   assign term_sum = {1'b0, hi_ff} + (HI_W+1)'(prod_ff[HI_W-1:HALF_W]);
   assign term_mag = SUM_W'(term_sum[HI_W:HALF_W]);
   assign pow_mag  = prod_ff[2*MUL_W-1:16];

   // shared multiplier operand select
   always_comb begin
      unique case (ctrl.op)
         OP_MUL_HI: begin
            mul_a = MUL_W'(c_mag[COEF_W-1:HALF_W]);
            mul_b = p_mag;
         end
         OP_MUL_LO: begin
            mul_a = MUL_W'(c_mag[HALF_W-1:0]);
            mul_b = p_mag;
         end
         OP_MUL_POW: begin
            mul_a = p_mag;
            mul_b = adc_mag;
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   always_comb begin
      rem_in       = rem_ff;
      quo_in       = quo_ff;
      ovf_in       = ovf_ff;
      adc_in       = adc_ff;
      p_in         = p_ff;
      i_in         = i_ff;
      hi_in        = hi_ff;
      prod_in      = prod_ff;
      sum_in       = sum_ff;
      sat_in       = sat_ff;
      out_e_in     = out_e_ff;
      out_sat_in   = out_sat_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      v36          = '0;
      clip_r       = '0;
      unique case (ctrl.op)
         OP_NOP: ;
         OP_DIV_INIT: begin
            rem_in = prefix;
            quo_in = '0;
            ovf_in = (prefix >= slope_ff);
            sat_in = 1'b0;
         end
         OP_DIV_STEP: begin
            if (rem_sh >= slope_ff) begin
               rem_in = rem_sh - slope_ff;
               quo_in = {quo_ff[QUO_W-2:0], 1'b1};
            end else begin
               rem_in = rem_sh;
               quo_in = {quo_ff[QUO_W-2:0], 1'b0};
            end
         end
         OP_ADC_CLIP: begin
            v36 = e_ff[ENERGY_W-1] ? -$signed({3'd0, quo_ff}) : $signed({3'd0, quo_ff});
            clip_r = clip_sum(v36);
            if (ovf_ff) begin
               clip_r.sat = 1'b1;
               clip_r.val = e_ff[ENERGY_W-1] ? CLIP_LO[ENERGY_W-1:0] : CLIP_HI[ENERGY_W-1:0];
            end
            adc_in = clip_r.val;
            sat_in = sat_ff | clip_r.sat;
         end
         OP_ADC_SUB: begin
            if (use_old_icpt && not_high_ff) begin
               v36 = SUM_W'(adc_ff) - SUM_W'(oi_t);
               clip_r = clip_sum(v36);
               adc_in = clip_r.val;
               p_in   = clip_r.val;
               sat_in = sat_ff | clip_r.sat;
            end else begin
               p_in = adc_ff;
            end
            sum_in = '0;
            i_in   = CNT_W'(1);
         end
         OP_MUL_HI: hi_in = HI_W'(mul_a * mul_b);
         OP_MUL_LO, OP_MUL_POW: prod_in = mul_a * mul_b;
         OP_TERM_ACC: begin
            sum_in = term_neg ? (sum_ff - $signed(term_mag)) : (sum_ff + $signed(term_mag));
            i_in   = i_next[CNT_W-1:0];
         end
         OP_POW_CLIP: begin
            v36 = pow_neg ? -$signed({1'b0, pow_mag[SUM_W-2:0]})
                          : $signed({1'b0, pow_mag[SUM_W-2:0]});
            clip_r = clip_sum(v36);
            if (|pow_mag[2*MUL_W-17:SUM_W-1]) begin
               clip_r.sat = 1'b1;
               clip_r.val = pow_neg ? CLIP_LO[ENERGY_W-1:0] : CLIP_HI[ENERGY_W-1:0];
            end
            p_in   = clip_r.val;
            sat_in = sat_ff | clip_r.sat;
         end
         OP_ADD_ICPT: begin
            if (use_new_icpt && not_high_ff) begin
               sum_in = sum_ff + SUM_W'(c0_t);
            end
         end
         OP_EMIT_SUM: begin
            clip_r       = clip_sum(sum_ff);
            out_e_in     = clip_r.val;
            out_sat_in   = sat_ff | clip_r.sat;
            out_valid_in = 1'b1;
         end
         OP_EMIT_PASS: begin
            out_e_in     = e_ff;
            out_sat_in   = 1'b0;
            out_valid_in = 1'b1;
         end
         default: ;
      endcase
   end

   // item capture
   always_ff @(posedge clock) begin
      if (ctrl.load) begin
         e_ff        <= req_tdata[E_LSB +: ENERGY_W];
         not_high_ff <= (req_tuser != '0);
         oi_ff       <= req_tdata[OI_LSB +: COEF_W];
         slope_ff    <= req_tdata[OS_LSB +: COEF_W];
         for (int k = 0; k < NUM_COEFF_FIELDS; k++) begin
            coef_ff[k] <= req_tdata[C0_LSB + k*COEF_W +: COEF_W];
         end
         cnt_ff <= (cnt_raw > CNT_W'(EFF_COEFFS)) ? CNT_W'(EFF_COEFFS) : cnt_raw;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff     <= rem_in;
      quo_ff     <= quo_in;
      ovf_ff     <= ovf_in;
      adc_ff     <= adc_in;
      p_ff       <= p_in;
      hi_ff      <= hi_in;
      prod_ff    <= prod_in;
      sum_ff     <= sum_in;
      sat_ff     <= sat_in;
      out_e_ff   <= out_e_in;
      out_sat_ff <= out_sat_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         i_ff         <= '0;
      end else begin
         out_valid_ff <= out_valid_in;
         i_ff         <= i_in;
      end
   end

   always_comb begin
      status.gate_ok    = !slope_ff[COEF_W-1] && (|slope_ff)
                          && !coef_ff[1][COEF_W-1] && (|coef_ff[1]);
      status.more_terms = (i_ff < cnt_ff);
      status.last_term  = (i_next >= {1'b0, cnt_ff});
      status.out_busy   = out_valid_ff && !rsp_tready;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_e_ff;
   assign rsp_tuser  = out_sat_ff;

   `ASSERT_HOLDS(a_emit_slot_free, clock, reset, ctrl.op == OP_EMIT_SUM || ctrl.op == OP_EMIT_PASS, !(out_valid_ff && !rsp_tready), "result overwritten")
   `ASSERT_NEXT(a_pass_no_sat, clock, reset, ctrl.op == OP_EMIT_PASS, !out_sat_ff, "pass-through flagged")
   `ASSERT_HOLDS(a_term_in_range, clock, reset, ctrl.op == OP_TERM_ACC, i_ff < cnt_ff, "term past count")

endmodule

@@ rtl/core/cell_energy_recalibration_unit.sv @@
// Cell energy recalibration unit.
// req channel: one item per cell: energy, old intercept and slope, four new
//   polynomial coefficients and a coefficient count in req_tdata, gain in req_tuser.
// rsp channel: one item per request: recalibrated energy in rsp_tdata, the
//   saturation flag in rsp_tuser.
// csr channel: two 1-bit control registers (old / new intercept enables), always
//   ready; write them only while no item is in flight.
// Pass-through items (slope or linear coefficient not positive) go from the gate
//   step straight to the emit step; recalibrated items run the divide, then steps
//   per polynomial term and per extra power. The sequencer is back at idle as the
//   result is written. The 33-step bit-serial divide and the single shared 32x32
//   multiplier are both run by the microcode sequencer. One item is in work at a
//   time; req_tready is high only while the sequencer sits at its idle step.
// Reset: sequencer to idle, no result pending, old intercept off, new on.
// Stall: a finished result waits in the output register; the next item may be
//   accepted and worked on meanwhile, and the sequencer holds only at its
//   emit step until the output register is free.
module cell_energy_recalibration_unit import cer_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   // energy_in, old_intercept, old_slope, coeff_zero, coeff_one, coeff_two,
   // coeff_three, coeff_count (lowest bits first), zero padded
   input  logic                   req_tvalid,
   output logic                   req_tready,
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic [GAIN_W-1:0]      req_tuser,   // gain_level
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   output logic [RSP_TDATA_W-1:0] rsp_tdata,   // energy_out
   output logic                   rsp_tuser,   // saturated
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   logic       use_old_ff, use_old_in;
   logic       use_new_ff, use_new_in;
   ctrl_type   ctrl;
   status_type status;

   assign csr_ready = 1'b1;

   // control registers
   always_comb begin
      use_old_in = use_old_ff;
      use_new_in = use_new_ff;
      if (csr_valid) begin
         unique case (csr_index)
            REG_USE_OLD_ICPT: use_old_in = csr_data[0];
            REG_USE_NEW_ICPT: use_new_in = csr_data[0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         use_old_ff <= 1'b0;
         use_new_ff <= 1'b1;
      end else begin
         use_old_ff <= use_old_in;
         use_new_ff <= use_new_in;
      end
   end

   // microcode sequencer
   cer_seq u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .ctrl       (ctrl)
   );

   // divider, shared multiplier, accumulator and result register
   cer_dp u_dp (
      .clock        (clock),
      .reset        (reset),
      .ctrl         (ctrl),
      .req_tdata    (req_tdata),
      .req_tuser    (req_tuser),
      .use_old_icpt (use_old_ff),
      .use_new_icpt (use_new_ff),
      .status       (status),
      .rsp_tvalid   (rsp_tvalid),
      .rsp_tready   (rsp_tready),
      .rsp_tdata    (rsp_tdata),
      .rsp_tuser    (rsp_tuser)
   );

endmodule

@@ tb/tb_cell_energy_recalibration_unit.sv @@
module tb_cell_energy_recalibration_unit;
   import cer_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   // ---------------------------------------------------------------------
   // Codes and handy constants
   // ---------------------------------------------------------------------
   localparam logic [GAIN_W-1:0] GAIN_HIGH   = 2'd0;
   localparam logic [GAIN_W-1:0] GAIN_MEDIUM = 2'd1;
   localparam logic [GAIN_W-1:0] GAIN_LOW    = 2'd2;
   localparam logic [GAIN_W-1:0] GAIN_SPARE  = 2'd3;   // decoded as a non-high gain

   localparam int PAD_W = REQ_TDATA_W - REQ_BITS;

   localparam longint I32_MAX  = 64'sd2147483647;
   localparam longint I32_MIN  = -64'sd2147483648;
   localparam longint COEF_MAX = 64'sd549755813887;
   localparam longint COEF_MIN = -64'sd549755813888;
   localparam longint ONE_Q32  = 64'sd4294967296;     // 1.0 in Q7.32
   localparam longint MEV      = 64'sd256;            // 1 MeV in Q23.8

   localparam int RX_HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES   = 60;    // outlasts the longest item

   // one input item, unpacked for the predictor
   typedef struct {
      logic signed [ENERGY_W-1:0]              energy;
      logic [GAIN_W-1:0]                       gain;
      logic signed [COEF_W-1:0]                old_icpt;
      logic signed [COEF_W-1:0]                old_slope;
      logic [NUM_COEFF_FIELDS-1:0][COEF_W-1:0] coeff;   // [0] is the new intercept
      logic [CNT_W-1:0]                        count;
   } cell_item_type;

   // one result item
   typedef struct {
      logic [ENERGY_W-1:0] energy;
      logic                sat;
   } recal_type;

   // ---------------------------------------------------------------------
   // DUT signals; every input starts at a known value
   // ---------------------------------------------------------------------
   logic                   clock;
   logic                   reset      = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata  = '0;
   logic [GAIN_W-1:0]      req_tuser  = '0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   rsp_tuser;
   logic                   csr_valid  = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index  = '0;
   logic [CSR_DATA_W-1:0]  csr_data   = '0;

   cell_energy_recalibration_unit dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // Hard stop, far beyond the slowest legal run.
   initial begin
      #4ms;
      $display("TEST FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Shared bookkeeping
   // ---------------------------------------------------------------------
   cell_item_type cells_to_send [$];
   recal_type     expected_energy [$];
   int            cells_queued   = 0;
   int            cells_accepted = 0;
   int            energies_seen  = 0;
   int            mismatch_cnt   = 0;

   // Mirror of the two enable registers; only touched while the block is idle.
   bit old_icpt_on = 1'b0;
   bit new_icpt_on = 1'b1;

   // ---------------------------------------------------------------------
   // Predictor
   // ---------------------------------------------------------------------
   function automatic logic [63:0] abs64(input longint x);
      return (x < 0) ? 64'(-x) : 64'(x);
   endfunction

   function automatic longint clamp_i32(input longint x, inout bit clipped);
      if (x > I32_MAX) begin
         clipped = 1'b1;
         return I32_MAX;
      end
      if (x < I32_MIN) begin
         clipped = 1'b1;
         return I32_MIN;
      end
      return x;
   endfunction

   // (coeff * power) / 2^40, magnitude truncated
   function automatic longint poly_term(input longint c, input longint p);
      logic [127:0] prod;
      longint       m;
      prod = 128'(abs64(c)) * 128'(abs64(p));
      m    = longint'(prod[103:40]);
      return ((c < 0) != (p < 0)) ? -m : m;
   endfunction

   // (power * adc) / 2^16, magnitude truncated, clipped to 32 bits
   function automatic longint next_adc_power(input longint p, input longint a,
                                             inout bit clipped);
      logic [127:0] prod;
      longint       m;
      prod = 128'(abs64(p)) * 128'(abs64(a));
      m    = longint'(prod[79:16]);
      return clamp_i32(((p < 0) != (a < 0)) ? -m : m, clipped);
   endfunction

   function automatic recal_type recal_energy(input cell_item_type it, input bit old_on,
                                              input bit new_on);
      recal_type    r;
      longint       e, slope, adc, pw, acc, mq;
      logic [127:0] quo;
      bit           not_high, clipped;
      int           n_coef;
      e        = longint'(it.energy);
      slope    = longint'(it.old_slope);
      not_high = (it.gain != GAIN_HIGH);
      clipped  = 1'b0;
      n_coef   = (it.count > EFF_COEFFS) ? EFF_COEFFS : int'(it.count);
      r.energy = it.energy;
      if (slope > 0 && longint'($signed(it.coeff[1])) > 0) begin
         // back to ADC counts: Q23.8 / Q7.32 -> Q15.16
         quo = (128'(abs64(e)) << 40) / 128'(slope);
         if (quo > 128'h1_0000_0000)
            quo = 128'h1_0000_0000;
         mq  = longint'(quo[63:0]);
         adc = clamp_i32((e < 0) ? -mq : mq, clipped);
         if (old_on && not_high)
            adc = clamp_i32(adc - longint'(it.old_icpt) / 64'sd65536, clipped);
         // forward through the new polynomial, first power upward
         pw  = adc;
         acc = 0;
         for (int i = 1; i < n_coef; i++) begin
            if (i > 1)
               pw = next_adc_power(pw, adc, clipped);
            acc += poly_term(longint'($signed(it.coeff[i])), pw);
         end
         if (new_on && not_high)
            acc += longint'($signed(it.coeff[0])) / 64'sd16777216;
         r.energy = ENERGY_W'(clamp_i32(acc, clipped));
      end
      r.sat = clipped;
      return r;
   endfunction

   // ---------------------------------------------------------------------
   // Stimulus builders
   // ---------------------------------------------------------------------
   function automatic cell_item_type make_cell(input longint e, input logic [GAIN_W-1:0] g,
                                               input longint oi, input longint os,
                                               input longint c0, input longint c1,
                                               input longint c2, input longint c3,
                                               input int cnt);
      cell_item_type it;
      it.energy    = ENERGY_W'(e);
      it.gain      = g;
      it.old_icpt  = COEF_W'(oi);
      it.old_slope = COEF_W'(os);
      it.coeff[0]  = COEF_W'(c0);
      it.coeff[1]  = COEF_W'(c1);
      it.coeff[2]  = COEF_W'(c2);
      it.coeff[3]  = COEF_W'(c3);
      it.count     = CNT_W'(cnt);
      return it;
   endfunction

   // signed value of random bit length, up to maxbits
   function automatic longint rand_signed(input int maxbits);
      longint v;
      int     nb;
      nb = $urandom_range(maxbits, 1);
      v  = longint'({$urandom, $urandom});
      return v >>> (64 - nb);
   endfunction

   // strictly positive value with between lo and hi bits
   function automatic longint rand_positive(input int lo, input int hi);
      logic [63:0] v;
      int          nb;
      nb = $urandom_range(hi, lo);
      v  = {$urandom, $urandom};
      v  = v >> (64 - nb);
      return (v == 0) ? 64'sd1 : longint'(v);
   endfunction

   function automatic cell_item_type random_cell();
      cell_item_type it;
      int            kind;
      kind    = $urandom_range(9, 0);
      it.gain = GAIN_W'($urandom_range(3, 0));
      if (kind < 2) begin
         // raw noise over every field; mostly lands in the pass-through path
         it.energy    = $urandom;
         it.old_icpt  = COEF_W'({$urandom, $urandom});
         it.old_slope = COEF_W'({$urandom, $urandom});
         for (int i = 0; i < NUM_COEFF_FIELDS; i++)
            it.coeff[i] = COEF_W'({$urandom, $urandom});
         it.count = CNT_W'($urandom_range(7, 0));
      end else begin
         // gate open: positive old slope and linear coefficient
         it.energy    = ENERGY_W'(rand_signed(ENERGY_W));
         it.old_icpt  = COEF_W'(rand_signed(COEF_W));
         it.old_slope = COEF_W'(rand_positive(24, COEF_W - 1));
         it.coeff[0]  = COEF_W'(rand_signed(COEF_W));
         it.coeff[1]  = COEF_W'(rand_positive(12, COEF_W - 1));
         it.coeff[2]  = COEF_W'(rand_signed(COEF_W));
         it.coeff[3]  = COEF_W'(rand_signed(COEF_W));
         it.count     = (kind == 2) ? CNT_W'($urandom_range(7, 0))
                                    : CNT_W'($urandom_range(4, 2));
      end
      return it;
   endfunction

   task automatic queue_cell(input cell_item_type it);
      cells_to_send.push_back(it);
      cells_queued++;
   endtask

   task automatic queue_random(input int n);
      repeat (n) queue_cell(random_cell());
   endtask

   task automatic queue_directed();
      // pass-through: slope zero, slope most negative, linear coeff zero / negative
      queue_cell(make_cell(I32_MAX, GAIN_MEDIUM, 0, 0, 0, ONE_Q32, 0, 0, 2));
      queue_cell(make_cell(I32_MIN, GAIN_HIGH, COEF_MAX, COEF_MIN, 0, ONE_Q32, 0, 0, 4));
      queue_cell(make_cell(1000 * MEV, GAIN_LOW, 0, ONE_Q32, 0, 0, 0, 0, 3));
      queue_cell(make_cell(1000 * MEV, GAIN_LOW, 0, ONE_Q32, 0, COEF_MIN, 0, 0, 3));
      // zero energy, intercept only
      queue_cell(make_cell(0, GAIN_LOW, 0, ONE_Q32, COEF_MAX, ONE_Q32, 0, 0, 2));
      // divide overflow, both signs; smallest and largest positive slope
      queue_cell(make_cell(I32_MAX, GAIN_MEDIUM, 0, 1, 0, ONE_Q32, 0, 0, 2));
      queue_cell(make_cell(I32_MIN, GAIN_SPARE, 0, 1, 0, ONE_Q32, 0, 0, 2));
      queue_cell(make_cell(-1, GAIN_MEDIUM, 0, COEF_MAX, 0, COEF_MAX, 0, 0, 2));
      // ordinary calibration over every gain and coefficient counts 0, 1, 3, 4, 5 and 7
      queue_cell(make_cell(1000 * MEV, GAIN_HIGH, 5 * ONE_Q32, ONE_Q32 / 2, 3 * ONE_Q32,
                           ONE_Q32, ONE_Q32 >> 10, -(ONE_Q32 >> 16), 4));
      queue_cell(make_cell(1000 * MEV, GAIN_MEDIUM, 5 * ONE_Q32, ONE_Q32 / 2, 3 * ONE_Q32,
                           ONE_Q32, ONE_Q32 >> 10, -(ONE_Q32 >> 16), 4));
      queue_cell(make_cell(-700 * MEV, GAIN_LOW, 5 * ONE_Q32, ONE_Q32 / 2, 3 * ONE_Q32,
                           ONE_Q32, ONE_Q32 >> 10, -(ONE_Q32 >> 16), 3));
      queue_cell(make_cell(1000 * MEV, GAIN_SPARE, 5 * ONE_Q32, ONE_Q32 / 2, 3 * ONE_Q32,
                           ONE_Q32, ONE_Q32 >> 10, -(ONE_Q32 >> 16), 0));
      queue_cell(make_cell(1000 * MEV, GAIN_MEDIUM, 5 * ONE_Q32, ONE_Q32 / 2, 3 * ONE_Q32,
                           ONE_Q32, ONE_Q32 >> 10, -(ONE_Q32 >> 16), 1));
      queue_cell(make_cell(1000 * MEV, GAIN_MEDIUM, 5 * ONE_Q32, ONE_Q32 / 2, 3 * ONE_Q32,
                           ONE_Q32, ONE_Q32 >> 10, -(ONE_Q32 >> 16), 5));
      queue_cell(make_cell(1000 * MEV, GAIN_LOW, 5 * ONE_Q32, ONE_Q32 / 2, 3 * ONE_Q32,
                           ONE_Q32, ONE_Q32 >> 10, -(ONE_Q32 >> 16), 7));
      // old intercept subtraction pushes ADC past either rail
      queue_cell(make_cell(64'sd1 << 29, GAIN_MEDIUM, COEF_MIN, (64'sd1 << 38) + 2, 0,
                           ONE_Q32, 0, 0, 2));
      queue_cell(make_cell(-(64'sd1 << 29), GAIN_LOW, COEF_MAX, (64'sd1 << 38) + 2, 0,
                           ONE_Q32, 0, 0, 2));
      // square clips
      queue_cell(make_cell(64'sd1 << 20, GAIN_MEDIUM, 0, ONE_Q32, 0, ONE_Q32, ONE_Q32, 0, 3));
      // final sum clips high, then low
      queue_cell(make_cell(64'sd1 << 20, GAIN_MEDIUM, 0, ONE_Q32, 0, COEF_MAX, COEF_MAX,
                           COEF_MAX, 4));
      queue_cell(make_cell(-(64'sd1 << 20), GAIN_MEDIUM, 0, ONE_Q32, 0, COEF_MAX, COEF_MIN,
                           COEF_MAX, 4));
      // new intercept extremes, smallest linear coefficient
      queue_cell(make_cell(MEV, GAIN_LOW, COEF_MAX, ONE_Q32, COEF_MIN, 1, 0, 0, 7));
      queue_cell(make_cell(1, GAIN_MEDIUM, COEF_MIN, 1, COEF_MAX, 1, COEF_MAX, COEF_MIN, 4));
   endtask

   // ---------------------------------------------------------------------
   // Register writes and phase control
   // ---------------------------------------------------------------------
   task automatic write_csr(input logic [CSR_INDEX_W-1:0] idx, input logic val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      // write took effect at this edge
      if (idx == REG_USE_OLD_ICPT)
         old_icpt_on = val;
      else
         new_icpt_on = val;
      csr_valid <= 1'b0;
   endtask

   task automatic set_intercepts(input logic old_on, input logic new_on);
      write_csr(REG_USE_OLD_ICPT, old_on);
      write_csr(REG_USE_NEW_ICPT, new_on);
   endtask

   // everything queued has been taken and answered
   task automatic wait_drained();
      while (cells_accepted != cells_queued || expected_energy.size() != 0)
         @(posedge clock);
   endtask

   // ---------------------------------------------------------------------
   // Test sequence
   //   phase 0: reset values of the enables, a few random items
   //   phase 1: both enables on, directed corner items then random
   //   phase 2: both off; sender holds off mid-phase until fully drained
   //   phase 3/4: one enable each
   // ---------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      queue_random(12);
      wait_drained();

      set_intercepts(1'b1, 1'b1);
      queue_directed();
      queue_random(450);
      wait_drained();

      set_intercepts(1'b0, 1'b0);
      queue_random(225);
      wait_drained();
      queue_random(225);
      wait_drained();

      set_intercepts(1'b1, 1'b0);
      queue_random(450);
      wait_drained();

      set_intercepts(1'b0, 1'b1);
      queue_random(450);
      wait_drained();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_cnt == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

   // ---------------------------------------------------------------------
   // Request driver: bursts of random length separated by random gaps.
   // The prediction is made when the item is actually taken, so it always
   // sees the enable settings in force at that moment.
   // ---------------------------------------------------------------------
   cell_item_type cur_cell;
   int            burst_left = 0;
   int            gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
         burst_left = 0;
         gap_left   = 0;
      end else begin
         if (req_tvalid && req_tready) begin
            expected_energy.push_back(recal_energy(cur_cell, old_icpt_on, new_icpt_on));
            cells_accepted++;
         end
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (cells_to_send.size() != 0) begin
               cur_cell = cells_to_send.pop_front();
               req_tdata <= {{PAD_W{1'b0}}, cur_cell.count, cur_cell.coeff,
                             cur_cell.old_slope, cur_cell.old_icpt, cur_cell.energy};
               req_tuser  <= cur_cell.gain;
               req_tvalid <= 1'b1;
               if (burst_left <= 1) begin
                  burst_left = $urandom_range(40, 1);
                  // about a third of bursts run straight into the next one
                  gap_left   = ($urandom_range(2, 0) == 0) ? 0 : $urandom_range(12, 1);
               end else begin
                  burst_left--;
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ---------------------------------------------------------------------
   // Response sink. Readiness pattern is redrawn at random from always ready,
   // coin flip, mostly stalled and a fixed duty cycle. Twice in the run it
   // holds off for a long stretch so the output register fills, the next
   // item finishes behind it and the input backs up.
   // ---------------------------------------------------------------------
   int rx_cycles    = 0;
   int rx_mode      = 0;
   int stall_left   = 0;
   int next_hold_at = 300;

   always @(posedge clock) begin
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         rx_cycles++;
         if (rx_cycles % 64 == 0)
            rx_mode = $urandom_range(3, 0);
         if (stall_left == 0 && energies_seen >= next_hold_at) begin
            stall_left   = RX_HOLD_CYCLES;
            next_hold_at += 800;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_tready <= 1'b0;
         end else begin
            case (rx_mode)
               0:       rsp_tready <= 1'b1;
               1:       rsp_tready <= 1'($urandom_range(1, 0));
               2:       rsp_tready <= ($urandom_range(3, 0) == 0);
               default: rsp_tready <= ((rx_cycles % 8) < 5);
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // Result checker
   // ---------------------------------------------------------------------
   recal_type want_energy;

   task automatic flag_mismatch(input string what, input logic [31:0] want,
                                input logic [31:0] got);
      mismatch_cnt++;
      if (mismatch_cnt <= 10)
         $display("%0t ns: result %0d %s: expected %h, got %h",
                  $time, energies_seen, what, want, got);
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         energies_seen++;
         if (expected_energy.size() == 0) begin
            flag_mismatch("unexpected", '0, rsp_tdata);
         end else begin
            want_energy = expected_energy.pop_front();
            if (rsp_tdata !== want_energy.energy)
               flag_mismatch("energy_out", want_energy.energy, rsp_tdata);
            if (rsp_tuser !== want_energy.sat)
               flag_mismatch("saturated", 32'(want_energy.sat), 32'(rsp_tuser));
         end
      end
   end

endmodule
